// ===== hw/rtl/hsbrgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsbrgb_pkg;

    // Fraction bits of the Q-format inputs
    localparam int FRAC_BITS_DEF = 12;

    // Input field and output channel widths
    localparam int IN_W  = 16;
    localparam int CH_W  = 8;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    // Alpha is always fully opaque
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Number of color channels derived from the hue ramp
    localparam int NUM_CH = 3;

    // Hue ramp segments
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } t_seg;

endpackage

`default_nettype wire

// ===== hw/rtl/hsb_to_rgb_color_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HSB to RGB pixel converter. Hue, saturation and brightness arrive as unsigned
// fixed-point numbers with FRAC_BITS fraction bits (1.0 = 1 << FRAC_BITS) and are
// first clamped to 1.0; a hue of 1.0 means a full turn. The pixel is formed the
// HSB -> RGB way in closed form: the top channel value is the brightness,
// the bottom one is brightness * (1 - saturation), and each of red, green and
// blue reads a piecewise hue ramp at the hue shifted by +1/3, 0 and -1/3 of a
// turn. Channels are scaled by 255 and truncated; zero brightness gives black,
// zero saturation gives grey, and alpha is always 255. The block is a four-stage
// pipeline (clamp and bottom-value multiply, hue wrap and segment select, ramp
// multiply, scale by 255), and one pixel can enter in every cycle unless every
// stage is full and the output is stalled. Each stage holds its data while the
// stage after it is full and stalled, so gaps close up and the input side keeps
// accepting while a finished pixel waits at the output.
module hsb_to_rgb_color_convert #(
    parameter int FRAC_BITS = hsbrgb_pkg::FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // slave side: [15:0] hue_in, [31:16] sat_in, [47:32] bri_in
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [hsbrgb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // master side: [7:0] red_out, [15:8] green_out, [23:16] blue_out,
    // [31:24] alpha_out
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [hsbrgb_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int IW   = hsbrgb_pkg::IN_W;
    localparam int CW   = hsbrgb_pkg::CH_W;
    localparam int NCH  = hsbrgb_pkg::NUM_CH;
    // value range 0..1.0
    localparam int VW   = FRAC_BITS + 1;
    // compare width for clamping
    localparam int KW   = (VW > IW) ? VW : IW;
    // hue times six, 0..6.0
    localparam int HW   = FRAC_BITS + 3;
    // signed shifted hue, -2.0..8.0
    localparam int SW   = FRAC_BITS + 5;
    localparam int NSTG = 4;

    localparam logic [KW-1:0]        ONE_K  = KW'(1) << FRAC_BITS;
    localparam logic [VW-1:0]        ONE_V  = VW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] ONE_S  = SW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] THIRD  = SW'(ONE_S * 2);
    localparam logic signed [SW-1:0] TURN   = SW'(ONE_S * 6);
    localparam logic signed [SW-1:0] T_HIGH = SW'(ONE_S * 3);
    localparam logic signed [SW-1:0] T_FALL = SW'(ONE_S * 4);

    // clamp one input field to 1.0
    function automatic logic [VW-1:0] clamp_one(input logic [IW-1:0] x);
        logic [KW-1:0] xe;
        xe = KW'(x);
        return (xe > ONE_K) ? ONE_V : VW'(xe);
    endfunction

    // handshake chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    always_comb begin
        w_rdy[NSTG-1] = ~r_vld[NSTG-1] | m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = ~r_vld[k] | w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: clamp, hue * 6, bottom value ----------------
    logic [VW-1:0]   w_h, w_s, w_b;
    logic [2*VW-1:0] w_mn_prod;
    logic [HW-1:0]   n_h6;
    logic [VW-1:0]   n_mn;
    logic [HW-1:0]   r_s0_h6;
    logic [VW-1:0]   r_s0_mx, r_s0_mn;

    always_comb begin
        w_h       = clamp_one(s_axis_tdata[IW-1:0]);
        w_s       = clamp_one(s_axis_tdata[2*IW-1:IW]);
        w_b       = clamp_one(s_axis_tdata[3*IW-1:2*IW]);
        n_h6      = (HW'(w_h) << 2) + (HW'(w_h) << 1);
        w_mn_prod = (2*VW)'(w_b) * (2*VW)'(ONE_V - w_s);
        n_mn      = VW'(w_mn_prod >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0_h6 <= n_h6;
            r_s0_mx <= w_b;
            r_s0_mn <= n_mn;
        end
    end

    // ---------------- stage 1: shift and wrap hue, pick segment ----------------
    hsbrgb_pkg::t_seg n_seg [NCH];
    logic [VW-1:0]    n_fac [NCH];
    hsbrgb_pkg::t_seg r_s1_seg[NCH];
    logic [VW-1:0]    r_s1_fac[NCH];
    logic [VW-1:0]    r_s1_delta, r_s1_mx, r_s1_mn;

    always_comb begin
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] off;
        t   = '0;
        off = '0;
        for (int c = 0; c < NCH; c++) begin
            // red leads by a third of a turn, blue trails by one
            case (c)
                0:       off = THIRD;
                2:       off = -THIRD;
                default: off = '0;
            endcase
            t = $signed(SW'(r_s0_h6)) + off;
            if (t < 0) begin
                t = t + TURN;
            end
            if (t > TURN) begin
                t = t - TURN;
            end
            if (t < ONE_S) begin
                n_seg[c] = hsbrgb_pkg::SEG_RISE;
                n_fac[c] = VW'(t);
            end else if (t < T_HIGH) begin
                n_seg[c] = hsbrgb_pkg::SEG_HIGH;
                n_fac[c] = '0;
            end else if (t < T_FALL) begin
                n_seg[c] = hsbrgb_pkg::SEG_FALL;
                n_fac[c] = VW'(T_FALL - t);
            end else begin
                n_seg[c] = hsbrgb_pkg::SEG_LOW;
                n_fac[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_seg   <= n_seg;
            r_s1_fac   <= n_fac;
            r_s1_delta <= r_s0_mx - r_s0_mn;
            r_s1_mx    <= r_s0_mx;
            r_s1_mn    <= r_s0_mn;
        end
    end

    // ---------------- stage 2: ramp multiply ----------------
    logic [VW-1:0] n_v [NCH];
    logic [VW-1:0] r_s2_v[NCH];

    always_comb begin
        logic [2*VW-1:0] prod;
        prod = '0;
        for (int c = 0; c < NCH; c++) begin
            prod = (2*VW)'(r_s1_delta) * (2*VW)'(r_s1_fac[c]);
            case (r_s1_seg[c])
                hsbrgb_pkg::SEG_RISE,
                hsbrgb_pkg::SEG_FALL: n_v[c] = r_s1_mn + VW'(prod >> FRAC_BITS);
                hsbrgb_pkg::SEG_HIGH: n_v[c] = r_s1_mx;
                default:              n_v[c] = r_s1_mn;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s2_v <= n_v;
        end
    end

    // ---------------- stage 3: scale by 255, truncate ----------------
    logic [CW-1:0] n_ch [NCH];
    logic [CW-1:0] r_s3_ch[NCH];

    always_comb begin
        logic [VW+CW-1:0] sc;
        sc = '0;
        for (int c = 0; c < NCH; c++) begin
            sc      = ((VW+CW)'(r_s2_v[c]) << CW) - (VW+CW)'(r_s2_v[c]);
            n_ch[c] = CW'(sc >> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s3_ch <= n_ch;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {hsbrgb_pkg::ALPHA_OPAQUE, r_s3_ch[2], r_s3_ch[1], r_s3_ch[0]};

    // ---------------- checks ----------------
    // hold a stalled result in the last stage
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !m_axis_tready) |=> r_vld[NSTG-1])
        else $error("result dropped while stalled");

    // input may stall only when every stage is full
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input stalled with a free stage");

    // ramp factors never exceed 1.0
    a_fac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s1_fac[0] <= ONE_V && r_s1_fac[1] <= ONE_V && r_s1_fac[2] <= ONE_V))
        else $error("ramp factor out of range");

    // channel values stay within 0..1.0
    a_v_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s2_v[0] <= ONE_V && r_s2_v[1] <= ONE_V && r_s2_v[2] <= ONE_V))
        else $error("channel value out of range");

endmodule

`default_nettype wire
